// ----- sv/first_fit_region_allocator_assert.svh -----
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, checked out of reset
`define FFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- sv/ffa_pkg.sv -----
// shared types, constants and helpers of the region allocator
package ffa_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_KEY = 2'd2;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_BASE  = 2'd2;
    localparam logic [1:0] OP_SIZE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] byte_size;
        logic [31:0] handle;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] new_handle;
        logic [31:0] region_base;
        logic [31:0] region_size;
    } t_res;

    typedef struct packed {
        logic [31:0]      base;
        logic [31:0]      size;
        logic             busy;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] prev;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_AL_CHK, S_SP, S_AL_W1, S_AL_W2,
        S_FR_CHK, S_FW_TST, S_FW_CHK, S_BW_TST, S_BW_CHK, S_FR_WB,
        S_LK_RD, S_LK_WR, S_Q_OUT
    } t_state;

    typedef enum logic [1:0] {RET_ALLOC, RET_FWD, RET_BWD} t_ret;

    function automatic logic [31:0] encode_handle(input logic [IDX_W-1:0] n,
                                                  input logic [31:0] key);
        logic [31:0] w;
        w = 32'(n);
        return w ^ (w << 11) ^ (w << 22) ^ key;
    endfunction

    function automatic logic [IDX_W-1:0] decode_handle(input logic [31:0] h,
                                                       input logic [31:0] key);
        logic [31:0] w;
        w = h ^ key;
        return w[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/first_fit_region_allocator.sv -----
// first-fit region allocator: request sequencer around a region table ram
// a zero-size allocate answers straight from idle, a query reads its entry and then answers,
// and a free answers at its entry check when ignored, else it merges free neighbors forward
// then backward first; allocate walks the list one entry per cycle and scans for an unused
// entry one per cycle; one request at a time on a one-read one-write table ram, o_busy high
// meanwhile; reset and a known-register config write while idle or clearing clear the
// table; results are strobed for one cycle on o_res_valid; the receiver cannot stall
module first_fit_region_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  ffa_pkg::t_req                   i_req,
    output logic                            o_res_valid,
    output ffa_pkg::t_res                   o_res,
    input  logic                            i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    import ffa_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic [31:0] r_heap_base, n_heap_base, r_heap_size, n_heap_size, r_key, n_key;
    logic [IDX_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [IDX_W-1:0] r_clr, n_clr, r_cur, n_cur, r_x, n_x, r_nb, n_nb;
    logic [IDX_W-1:0] r_spd, n_spd, r_spare, n_spare, r_lk, n_lk, r_lk_val, n_lk_val;
    logic [IDX_W:0]   r_sp, n_sp;
    logic r_spv, n_spv, r_lk_prev, n_lk_prev;
    logic [1:0]  r_op, n_op;
    logic [31:0] r_size_req, n_size_req;
    t_entry r_ent, n_ent;
    logic r_res_valid, n_res_valid;
    t_res r_res, n_res;
    logic cfg_hit;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata, lk_data;
    logic [ENTRY_W-1:0] ram_rbits;

    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_entry'(ram_rbits);

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // write to a known configuration register
    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_HEAP_BASE || i_cfg_idx == CFG_HEAP_SIZE ||
                                  i_cfg_idx == CFG_HANDLE_KEY);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
            r_heap_base <= 32'd0;
            r_heap_size <= 32'd1048576;
            r_key       <= 32'd0;
            r_head      <= '0;
            r_tail      <= '0;
            r_spv       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
            r_heap_base <= n_heap_base;
            r_heap_size <= n_heap_size;
            r_key       <= n_key;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_spv       <= n_spv;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_cur      <= n_cur;
        r_x        <= n_x;
        r_nb       <= n_nb;
        r_spd      <= n_spd;
        r_spare    <= n_spare;
        r_lk       <= n_lk;
        r_lk_val   <= n_lk_val;
        r_lk_prev  <= n_lk_prev;
        r_sp       <= n_sp;
        r_op       <= n_op;
        r_size_req <= n_size_req;
        r_ent      <= n_ent;
        r_res      <= n_res;
    end

    // link field update for read-modify-write
    always_comb begin
        lk_data = ram_rdata;
        if (r_lk_prev) begin
            lk_data.prev = r_lk_val;
        end else begin
            lk_data.next = r_lk_val;
        end
    end

    // request sequencer
    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_heap_base = r_heap_base;
        n_heap_size = r_heap_size;                n_key = r_key;
        n_head = r_head;     n_tail = r_tail;     n_clr = r_clr;
        n_cur = r_cur;       n_x = r_x;           n_nb = r_nb;
        n_spd = r_spd;       n_spare = r_spare;   n_lk = r_lk;
        n_lk_val = r_lk_val; n_lk_prev = r_lk_prev;
        n_sp = r_sp;         n_spv = r_spv;       n_op = r_op;
        n_size_req = r_size_req;                  n_ent = r_ent;
        n_res_valid = 1'b0;  n_res = r_res;
        ram_we = 1'b0;       ram_waddr = '0;      ram_wdata = '0;
        ram_raddr = '0;

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == '0) begin
                    ram_wdata.base = r_heap_base;
                    ram_wdata.size = r_heap_size;
                end
                n_head = '0;
                n_tail = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!cfg_hit && i_start) begin
                    n_op       = i_req.operation;
                    n_size_req = i_req.byte_size;
                    n_x        = decode_handle(i_req.handle, r_key);
                    if (i_req.operation == OP_ALLOC) begin
                        if (i_req.byte_size == 32'd0) begin
                            n_res_valid = 1'b1;
                            n_res       = '{ST_ZERO, 32'd0, 32'd0, 32'd0};
                        end else begin
                            ram_raddr = r_head;
                            n_cur     = r_head;
                            n_state   = S_AL_CHK;
                        end
                    end else begin
                        ram_raddr = decode_handle(i_req.handle, r_key);
                        n_state   = (i_req.operation == OP_FREE) ? S_FR_CHK : S_Q_OUT;
                    end
                end
            end
            // first-fit list walk, one entry per cycle
            S_AL_CHK: begin
                if (!ram_rdata.busy && ram_rdata.size >= r_size_req) begin
                    n_ent = ram_rdata;
                    if (ram_rdata.size == r_size_req) begin
                        ram_we         = 1'b1;
                        ram_waddr      = r_cur;
                        ram_wdata      = ram_rdata;
                        ram_wdata.busy = 1'b1;
                        n_res_valid    = 1'b1;
                        n_res = '{ST_OK, encode_handle(r_cur, r_key), 32'd0, 32'd0};
                        n_state        = S_IDLE;
                    end else begin
                        n_sp    = '0;
                        n_spv   = 1'b0;
                        n_state = S_SP;
                    end
                end else if (r_cur == r_tail) begin
                    n_res_valid = 1'b1;
                    n_res       = '{ST_NOFIT, 32'd0, 32'd0, 32'd0};
                    n_state     = S_IDLE;
                end else begin
                    ram_raddr = ram_rdata.next;
                    n_cur     = ram_rdata.next;
                end
            end
            // pipelined scan for the lowest unused entry
            S_SP: begin
                ram_raddr = r_sp[IDX_W-1:0];
                n_spv     = !r_sp[IDX_W];
                n_spd     = r_sp[IDX_W-1:0];
                if (!r_sp[IDX_W]) begin
                    n_sp = r_sp + 1'b1;
                end
                if (r_spv && ram_rdata.size == 32'd0) begin
                    n_spare = r_spd;
                    n_spv   = 1'b0;
                    n_state = S_AL_W1;
                end else if (r_spv && r_spd == LAST) begin
                    n_spv       = 1'b0;
                    n_res_valid = 1'b1;
                    n_res       = '{ST_FULL, 32'd0, 32'd0, 32'd0};
                    n_state     = S_IDLE;
                end
            end
            S_AL_W1: begin
                ram_we         = 1'b1;
                ram_waddr      = r_spare;
                ram_wdata.base = r_ent.base + r_size_req;
                ram_wdata.size = r_ent.size - r_size_req;
                ram_wdata.busy = 1'b0;
                ram_wdata.next = r_ent.next;
                ram_wdata.prev = r_cur;
                n_state        = S_AL_W2;
            end
            S_AL_W2: begin
                ram_we         = 1'b1;
                ram_waddr      = r_cur;
                ram_wdata      = r_ent;
                ram_wdata.size = r_size_req;
                ram_wdata.busy = 1'b1;
                ram_wdata.next = r_spare;
                if (r_cur == r_tail) begin
                    n_tail      = r_spare;
                    n_res_valid = 1'b1;
                    n_res = '{ST_OK, encode_handle(r_cur, r_key), 32'd0, 32'd0};
                    n_state     = S_IDLE;
                end else begin
                    n_lk      = r_ent.next;
                    n_lk_prev = 1'b1;
                    n_lk_val  = r_spare;
                    n_ret     = RET_ALLOC;
                    n_state   = S_LK_RD;
                end
            end
            S_FR_CHK: begin
                if (ram_rdata.size == 32'd0 || !ram_rdata.busy) begin
                    n_res_valid = 1'b1;
                    n_res       = '{ST_IGNORED, 32'd0, 32'd0, 32'd0};
                    n_state     = S_IDLE;
                end else begin
                    n_ent      = ram_rdata;
                    n_ent.busy = 1'b0;
                    n_state    = S_FW_TST;
                end
            end
            // forward merge
            S_FW_TST: begin
                if (r_x == r_tail) begin
                    n_state = S_BW_TST;
                end else begin
                    ram_raddr = r_ent.next;
                    n_nb      = r_ent.next;
                    n_state   = S_FW_CHK;
                end
            end
            S_FW_CHK: begin
                if (ram_rdata.busy) begin
                    n_state = S_BW_TST;
                end else begin
                    n_ent.size = r_ent.size + ram_rdata.size;
                    n_ent.next = ram_rdata.next;
                    ram_we     = 1'b1;
                    ram_waddr  = r_nb;
                    if (r_nb == r_tail) begin
                        n_tail  = r_x;
                        n_state = S_FW_TST;
                    end else begin
                        n_lk      = ram_rdata.next;
                        n_lk_prev = 1'b1;
                        n_lk_val  = r_x;
                        n_ret     = RET_FWD;
                        n_state   = S_LK_RD;
                    end
                end
            end
            // backward merge
            S_BW_TST: begin
                if (r_x == r_head) begin
                    n_state = S_FR_WB;
                end else begin
                    ram_raddr = r_ent.prev;
                    n_nb      = r_ent.prev;
                    n_state   = S_BW_CHK;
                end
            end
            S_BW_CHK: begin
                if (ram_rdata.busy) begin
                    n_state = S_FR_WB;
                end else begin
                    n_ent.base = ram_rdata.base;
                    n_ent.size = r_ent.size + ram_rdata.size;
                    n_ent.prev = ram_rdata.prev;
                    ram_we     = 1'b1;
                    ram_waddr  = r_nb;
                    if (r_nb == r_head) begin
                        n_head  = r_x;
                        n_state = S_BW_TST;
                    end else begin
                        n_lk      = ram_rdata.prev;
                        n_lk_prev = 1'b0;
                        n_lk_val  = r_x;
                        n_ret     = RET_BWD;
                        n_state   = S_LK_RD;
                    end
                end
            end
            S_FR_WB: begin
                ram_we      = 1'b1;
                ram_waddr   = r_x;
                ram_wdata   = r_ent;
                n_res_valid = 1'b1;
                n_res       = '{ST_OK, 32'd0, 32'd0, 32'd0};
                n_state     = S_IDLE;
            end
            // neighbor link read-modify-write
            S_LK_RD: begin
                ram_raddr = r_lk;
                n_state   = S_LK_WR;
            end
            S_LK_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_lk;
                ram_wdata = lk_data;
                unique case (r_ret)
                    RET_ALLOC: begin
                        n_res_valid = 1'b1;
                        n_res = '{ST_OK, encode_handle(r_cur, r_key), 32'd0, 32'd0};
                        n_state     = S_IDLE;
                    end
                    RET_FWD: n_state = S_FW_TST;
                    RET_BWD: n_state = S_BW_TST;
                    default: n_state = S_IDLE;
                endcase
            end
            S_Q_OUT: begin
                n_res_valid = 1'b1;
                if (r_op == OP_BASE) begin
                    n_res = '{ST_OK, 32'd0, ram_rdata.base, 32'd0};
                end else begin
                    n_res = '{ST_OK, 32'd0, 32'd0, ram_rdata.size};
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // configuration writes while idle or clearing restart the clearing pass
        if (cfg_hit && (r_state == S_IDLE || r_state == S_CLR)) begin
            if (i_cfg_idx == CFG_HEAP_BASE) n_heap_base = i_cfg_data;
            if (i_cfg_idx == CFG_HEAP_SIZE) n_heap_size = i_cfg_data;
            if (i_cfg_idx == CFG_HANDLE_KEY) n_key = i_cfg_data;
            n_clr   = '0;
            n_state = S_CLR;
        end
    end

`include "first_fit_region_allocator_assert.svh"

    // results leave only as the sequencer returns to idle
    `FFA_ASSERT_IMPL(a_res_at_idle, r_res_valid, r_state == S_IDLE)
    // an accepted request either answers at once or keeps the block busy
    `FFA_ASSERT_NEXT(a_start_busy, i_start && !o_busy && !i_cfg_we, o_busy || o_res_valid)
    // the table is never written while idle
    `FFA_ASSERT_IMPL(a_no_idle_write, ram_we, r_state != S_IDLE)
    // the spare scan stays inside the table
    `FFA_ASSERT_IMPL(a_scan_range, r_state == S_SP && r_sp[IDX_W], r_sp[IDX_W-1:0] == '0)

endmodule

// ----- sv/ffa_ram.sv -----
// generic single-write, single-read ram with registered read data
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the first-fit region allocator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int          CYCLE_LIMIT = 40_000_000;
    localparam int unsigned NENT        = TABLE_ENTRIES;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_req                 i_req;
    logic                 o_res_valid;
    t_res                 o_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    first_fit_region_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // directed stimulus row
    typedef struct {
        t_req r;
        bit   typed;
        t_res res;
    } t_row;

    // shadow of the allocator configuration and region table
    logic [31:0]      cfg_base, cfg_size, cfg_key;
    logic [31:0]      rgn_base [NENT];
    logic [31:0]      rgn_size [NENT];
    logic             rgn_busy [NENT];
    logic [IDX_W-1:0] rgn_next [NENT];
    logic [IDX_W-1:0] rgn_prev [NENT];
    logic [IDX_W-1:0] rgn_head, rgn_tail;

    t_res        pending_res[$];
    logic [31:0] live_handles[$];
    t_row        rows[$];
    int          mismatches;
    int          cycles;
    int          burst_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle counter with timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // result checker, samples mid-cycle
    always @(negedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pending_res.size() == 0) begin
                report("unexpected result", 32'(o_res.status), 32'd0);
            end else begin
                want = pending_res.pop_front();
                if (o_res.status !== want.status)
                    report("status", 32'(o_res.status), 32'(want.status));
                if (o_res.new_handle !== want.new_handle)
                    report("new_handle", o_res.new_handle, want.new_handle);
                if (o_res.region_base !== want.region_base)
                    report("region_base", o_res.region_base, want.region_base);
                if (o_res.region_size !== want.region_size)
                    report("region_size", o_res.region_size, want.region_size);
            end
        end
    end

    function automatic void table_init();
        for (int i = 0; i < NENT; i++) begin
            rgn_base[i] = '0;
            rgn_size[i] = '0;
            rgn_busy[i] = 1'b0;
            rgn_next[i] = '0;
            rgn_prev[i] = '0;
        end
        rgn_base[0] = cfg_base;
        rgn_size[0] = cfg_size;
        rgn_head    = '0;
        rgn_tail    = '0;
    endfunction

    function automatic logic [31:0] scramble(input logic [IDX_W-1:0] n);
        logic [31:0] w;
        w = {{(32-IDX_W){1'b0}}, n};
        return w ^ (w << 11) ^ (w << 22) ^ cfg_key;
    endfunction

    function automatic void rgn_unlink(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] p, n;
        p = rgn_prev[x];
        n = rgn_next[x];
        if (x == rgn_head) rgn_head = n; else rgn_next[p] = n;
        if (x == rgn_tail) rgn_tail = p; else rgn_prev[n] = p;
    endfunction

    function automatic void rgn_clear(input logic [IDX_W-1:0] x);
        rgn_base[x] = '0;
        rgn_size[x] = '0;
        rgn_busy[x] = 1'b0;
        rgn_next[x] = '0;
        rgn_prev[x] = '0;
    endfunction

    // first-fit allocation on the shadow table
    function automatic t_res alloc_region(input logic [31:0] req);
        t_res             res;
        logic [IDX_W-1:0] cur, spare, n;
        bit               found, have_spare;
        res = '0;
        found = 0;
        have_spare = 0;
        if (req == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        cur = rgn_head;
        for (int k = 0; k < NENT; k++) begin
            if (!rgn_busy[cur] && rgn_size[cur] >= req) begin
                found = 1;
                break;
            end
            if (cur == rgn_tail) break;
            cur = rgn_next[cur];
        end
        if (!found) begin
            res.status = ST_NOFIT;
            return res;
        end
        if (rgn_size[cur] != req) begin
            for (int s = 0; s < NENT; s++) begin
                if (rgn_size[s] == 0) begin
                    spare = IDX_W'(s);
                    have_spare = 1;
                    break;
                end
            end
            if (!have_spare) begin
                res.status = ST_FULL;
                return res;
            end
            // link the remainder right after the taken region
            n = rgn_next[cur];
            rgn_prev[spare] = cur;
            rgn_next[spare] = n;
            if (cur == rgn_tail) rgn_tail = spare; else rgn_prev[n] = spare;
            rgn_next[cur] = spare;
            rgn_base[spare] = rgn_base[cur] + req;
            rgn_size[spare] = rgn_size[cur] - req;
            rgn_busy[spare] = 1'b0;
            rgn_size[cur] = req;
        end
        rgn_busy[cur] = 1'b1;
        res.status = ST_OK;
        res.new_handle = scramble(cur);
        return res;
    endfunction

    // release with forward then backward merge
    function automatic logic [2:0] free_region(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] nb;
        if (rgn_size[x] == 0 || !rgn_busy[x]) return ST_IGNORED;
        rgn_busy[x] = 1'b0;
        for (int k = 0; k < NENT && x != rgn_tail; k++) begin
            nb = rgn_next[x];
            if (rgn_busy[nb]) break;
            rgn_size[x] += rgn_size[nb];
            rgn_unlink(nb);
            rgn_clear(nb);
        end
        for (int k = 0; k < NENT && x != rgn_head; k++) begin
            nb = rgn_prev[x];
            if (rgn_busy[nb]) break;
            rgn_base[x] = rgn_base[nb];
            rgn_size[x] += rgn_size[nb];
            rgn_unlink(nb);
            rgn_clear(nb);
        end
        return ST_OK;
    endfunction

    function automatic t_res predict_result(input t_req r);
        t_res             res;
        logic [IDX_W-1:0] x;
        res = '0;
        x = IDX_W'(r.handle ^ cfg_key);
        case (r.operation)
            OP_ALLOC: res = alloc_region(r.byte_size);
            OP_FREE:  res.status = free_region(x);
            OP_BASE:  res.region_base = rgn_base[x];
            default:  res.region_size = rgn_size[x];
        endcase
        return res;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] sz,
                                    input logic [31:0] h, input bit typed,
                                    input logic [2:0] st, input logic [31:0] nh,
                                    input logic [31:0] rb, input logic [31:0] rs);
        t_row row;
        row.r     = '{operation: op, byte_size: sz, handle: h};
        row.typed = typed;
        row.res   = '{status: st, new_handle: nh, region_base: rb, region_size: rs};
        rows.push_back(row);
    endfunction

    // stop requesting and wait until every pending result has come back
    task automatic drain();
        i_start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_HEAP_BASE:  cfg_base = data;
            CFG_HEAP_SIZE:  cfg_size = data;
            default:        cfg_key  = data;
        endcase
        table_init();
        live_handles.delete();
    endtask

    task automatic configure(input logic [31:0] b, input logic [31:0] s, input logic [31:0] k);
        cfg_write(CFG_HEAP_BASE, b);
        cfg_write(CFG_HEAP_SIZE, s);
        cfg_write(CFG_HANDLE_KEY, k);
    endtask

    // send one request in bursts with random gaps, then predict on acceptance
    task automatic send_request(input t_req r, input bit typed, input t_res typed_res);
        int   gap;
        bit   was_busy;
        t_res res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_req   <= r;
        forever begin
            @(negedge i_clk);
            was_busy = o_busy;
            @(posedge i_clk);
            if (!was_busy) break;
        end
        res = predict_result(r);
        if (r.operation == OP_ALLOC && res.status == ST_OK)
            live_handles.push_back(res.new_handle);
        pending_res.push_back(typed ? typed_res : res);
    endtask

    // random request; alloc_pct sets the share of allocations
    task automatic random_request(input int alloc_pct, input int max_sz);
        t_req r;
        int   pick, idx;
        r.byte_size = $urandom_range(1, max_sz);
        r.handle    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            r.operation = OP_ALLOC;
            case ($urandom_range(0, 19))
                0:       r.byte_size = 0;
                1:       r.byte_size = $urandom;
                2:       r.byte_size = 32'hFFFF_FFFF;
                default: ;
            endcase
        end else begin
            r.operation = (pick < alloc_pct + (100 - alloc_pct) / 2) ? OP_FREE :
                          ($urandom_range(0, 1) ? OP_BASE : OP_SIZE);
            if (live_handles.size() != 0 && $urandom_range(0, 9) < 8) begin
                idx = $urandom_range(0, live_handles.size() - 1);
                r.handle = live_handles[idx];
                if (r.operation == OP_FREE) live_handles.delete(idx);
            end
        end
        send_request(r, 1'b0, '0);
    endtask

    initial begin
        t_res none;
        none       = '0;
        mismatches = 0;
        cycles     = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        cfg_base   = 32'd0;
        cfg_size   = 32'd1048576;
        cfg_key    = 32'd0;
        table_init();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, key zero, heap of 1 MiB at address zero
        add_row(OP_ALLOC, 32'd0,          32'd0, 1, ST_ZERO,    0, 0, 0);
        add_row(OP_ALLOC, 32'hFFFF_FFFF,  32'd0, 1, ST_NOFIT,   0, 0, 0);
        add_row(OP_SIZE,  32'd0,          32'd0, 1, ST_OK,      0, 0, 32'd1048576);
        add_row(OP_BASE,  32'hFFFF_FFFF,  32'd0, 1, ST_OK,      0, 0, 0);
        add_row(OP_FREE,  32'd0,          32'd0, 1, ST_IGNORED, 0, 0, 0);
        add_row(OP_FREE,  32'd0,          32'd5, 1, ST_IGNORED, 0, 0, 0);
        add_row(OP_SIZE,  32'd0,  32'hFFFF_FFFF, 1, ST_OK,      0, 0, 0);
        add_row(OP_ALLOC, 32'd16,         32'd0, 1, ST_OK,      0, 0, 0);
        add_row(OP_ALLOC, 32'd1048560,    32'd0, 1, ST_OK,      32'h0040_0801, 0, 0);
        add_row(OP_ALLOC, 32'd1,          32'd0, 1, ST_NOFIT,   0, 0, 0);
        add_row(OP_BASE,  32'd0,  32'h0040_0801, 1, ST_OK,      0, 32'd16, 0);
        add_row(OP_FREE,  32'd0,  32'h0040_0801, 1, ST_OK,      0, 0, 0);
        add_row(OP_FREE,  32'd0,  32'h0040_0801, 1, ST_IGNORED, 0, 0, 0);
        add_row(OP_ALLOC, 32'd8,          32'd0, 0, 0, 0, 0, 0);
        add_row(OP_FREE,  32'd0,          32'd0, 0, 0, 0, 0, 0);
        add_row(OP_SIZE,  32'd0,          32'd0, 0, 0, 0, 0, 0);
        add_row(OP_FREE,  32'd0,  32'h0040_0801, 0, 0, 0, 0, 0);
        add_row(OP_SIZE,  32'd0,          32'd0, 0, 0, 0, 0, 0);
        add_row(OP_BASE,  32'd0,  32'hFFFF_F800, 0, 0, 0, 0, 0);
        foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].res);

        // heap that wraps past the top of the address space
        configure(32'hFFFF_FF00, 32'h0000_0200, $urandom);
        repeat (120) random_request(55, 64);

        // empty heap, all-ones key
        configure($urandom, 32'd0, 32'hFFFF_FFFF);
        repeat (20) random_request(60, 64);

        // huge heap filled with many small regions
        configure($urandom, 32'hFFFF_FFFF, $urandom);
        repeat (700) random_request(95, 48);
        repeat (80) random_request(40, 48);

        // back to defaults with heavy churn and merging
        configure(32'd0, 32'd1048576, 32'd0);
        repeat (110) random_request(50, 4096);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
